>>> rtl/mdt_pkg.sv
package mdt_pkg;

  // Fixed field widths
  localparam int WORD_W     = 32;
  localparam int PRESCALE_W = 3;
  localparam int STEP_W     = 3;
  localparam int PROD_W     = 2 * WORD_W;

  // Defaults for the top-level parameters
  localparam int CLOCK_HZ_DEF    = 8000000;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Decimal scaling
  localparam int MAX_DEC_STEPS = 6;
  // floor(x / 10) == (x * RECIP10) >> RECIP_SHIFT for every 32-bit x
  localparam logic [WORD_W-1:0] RECIP10 = 32'hCCCC_CCCD;
  localparam int RECIP_SHIFT = 35;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TICK  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [WORD_W-1:0] usec;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_UWB,
    ST_DIVP,
    ST_PWB,
    ST_FIN
  } state_e;

  // Tick frequency with up to MAX_DEC_STEPS trailing decimal zeros stripped (elaboration only)
  function automatic logic [WORD_W-1:0] strip_freq(input logic [WORD_W-1:0] f);
    logic [WORD_W-1:0] v;
    v = (f == '0) ? WORD_W'(1) : f;
    for (int i = 0; i < MAX_DEC_STEPS; i++) begin
      if (v % 10 == 0) v = v / 10;
    end
    return v;
  endfunction

  // Decimal steps left after stripping (elaboration only)
  function automatic logic [STEP_W-1:0] strip_steps(input logic [WORD_W-1:0] f);
    logic [WORD_W-1:0] v;
    logic [STEP_W-1:0] s;
    v = (f == '0) ? WORD_W'(1) : f;
    s = STEP_W'(MAX_DEC_STEPS);
    for (int i = 0; i < MAX_DEC_STEPS; i++) begin
      if (v % 10 == 0) begin
        v = v / 10;
        s = s - STEP_W'(1);
      end
    end
    return s;
  endfunction

endpackage

>>> rtl/mdt_front.sv
module mdt_front (
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         action_i,
  input  logic [mdt_pkg::WORD_W-1:0]   microseconds_i,
  input  mdt_pkg::q_stat_t             q_stat_i,
  output logic                         push_o,
  output mdt_pkg::item_t               item_o
);
  import mdt_pkg::*;

  // Hold off requests while the queue has no room
  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  // Classify the request
  always_comb begin
    item_o.kind = action_i ? KIND_TICK : KIND_START;
    item_o.usec = microseconds_i;
  end

endmodule

>>> rtl/mdt_queue.sv
module mdt_queue #(
  parameter int DEPTH = mdt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mdt_pkg::item_t   item_i,
  input  logic             pop_i,
  output mdt_pkg::item_t   head_o,
  output mdt_pkg::q_stat_t stat_o
);
  import mdt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign stat_o.full  = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) count_d = count_q + CNT_W'(1);
    else if (!do_push && do_pop) count_d = count_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

>>> rtl/mdt_back.sv
module mdt_back #(
  parameter int CLOCK_HZ = mdt_pkg::CLOCK_HZ_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mdt_pkg::PRESCALE_W-1:0] cfg_data_i,
  input  mdt_pkg::item_t                 head_i,
  input  mdt_pkg::q_stat_t               q_stat_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           busy_res_o,
  output logic                           done_res_o,
  output logic [mdt_pkg::WORD_W-1:0]     ticks_left_o
);
  import mdt_pkg::*;

  localparam int TAB_N = 2 ** PRESCALE_W;

  // Per-prescale frequency and leftover decimal steps
  logic [WORD_W-1:0] freq_tab  [TAB_N];
  logic [STEP_W-1:0] steps_tab [TAB_N];

  for (genvar p = 0; p < TAB_N; p++) begin : g_tab
    assign freq_tab[p]  = strip_freq(WORD_W'(CLOCK_HZ) >> p);
    assign steps_tab[p] = strip_steps(WORD_W'(CLOCK_HZ) >> p);
  end

  state_e            state_q, state_d;
  logic [PRESCALE_W-1:0] prescale_q;
  logic [WORD_W-1:0] freq_q, usec_q, val_q, rem_q;
  logic [STEP_W-1:0] steps_q;
  logic [PROD_W-1:0] prod_q;
  logic              running_q;

  logic              out_valid_q, out_busy_q, out_done_q;
  logic [WORD_W-1:0] out_ticks_q;

  // Control from the output decoder
  logic              out_free;
  logic              load, mul_en, steps_dec, usec_wb, val_ld, val_wb;
  logic              emit_tick, emit_start;
  logic [WORD_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] mul_res;

  logic              need_div;
  logic [WORD_W-1:0] rem_dec, start_rem;
  logic              expire;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign need_div  = (steps_q != '0) && (prod_q[PROD_W-1:WORD_W] != '0);
  assign mul_res   = mul_a * mul_b;
  assign rem_dec   = rem_q - ((rem_q != '0) ? WORD_W'(1) : WORD_W'(0));
  assign expire    = running_q && (rem_dec == '0);
  assign start_rem = (val_q == '0) ? WORD_W'(1) : val_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty && head_i.kind == KIND_START) state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_CHK;
      ST_CHK: begin
        if (need_div)              state_d = ST_UWB;
        else if (steps_q != '0)    state_d = ST_DIVP;
        else                       state_d = ST_FIN;
      end
      ST_UWB:  state_d = ST_MUL;
      ST_DIVP: state_d = ST_PWB;
      ST_PWB:  state_d = (steps_q != '0) ? ST_DIVP : ST_FIN;
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pop_o      = 1'b0;
    load       = 1'b0;
    mul_en     = 1'b0;
    steps_dec  = 1'b0;
    usec_wb    = 1'b0;
    val_ld     = 1'b0;
    val_wb     = 1'b0;
    emit_tick  = 1'b0;
    emit_start = 1'b0;
    mul_a      = usec_q;
    mul_b      = freq_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          if (head_i.kind == KIND_TICK) begin
            pop_o     = out_free;
            emit_tick = out_free;
          end else begin
            pop_o = 1'b1;
            load  = 1'b1;
          end
        end
      end
      ST_MUL: mul_en = 1'b1;
      ST_CHK: begin
        if (need_div) begin
          mul_en    = 1'b1;
          mul_b     = RECIP10;
          steps_dec = 1'b1;
        end else begin
          val_ld = 1'b1;
        end
      end
      ST_UWB: usec_wb = 1'b1;
      ST_DIVP: begin
        mul_en    = 1'b1;
        mul_a     = val_q;
        mul_b     = RECIP10;
        steps_dec = 1'b1;
      end
      ST_PWB: val_wb = 1'b1;
      ST_FIN: emit_start = out_free;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prescale_q  <= '0;
      running_q   <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) prescale_q <= cfg_data_i;
      if (emit_tick && running_q) begin
        rem_q <= rem_dec;
        if (expire) running_q <= 1'b0;
      end else if (emit_start) begin
        rem_q     <= start_rem;
        running_q <= 1'b1;
      end
      if (emit_tick || emit_start) out_valid_q <= 1'b1;
      else if (!out_stall_i)       out_valid_q <= 1'b0;
    end
  end

  // Conversion datapath and result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      freq_q  <= freq_tab[prescale_q];
      steps_q <= steps_tab[prescale_q];
      usec_q  <= head_i.usec;
    end
    if (steps_dec) steps_q <= steps_q - STEP_W'(1);
    if (mul_en)    prod_q  <= mul_res;
    if (usec_wb)   usec_q  <= WORD_W'(prod_q[PROD_W-1:RECIP_SHIFT]);
    if (val_ld)    val_q   <= prod_q[WORD_W-1:0];
    if (val_wb)    val_q   <= WORD_W'(prod_q[PROD_W-1:RECIP_SHIFT]);
    if (emit_tick) begin
      out_busy_q  <= running_q && !expire;
      out_done_q  <= expire;
      out_ticks_q <= (running_q && !expire) ? rem_dec : '0;
    end else if (emit_start) begin
      out_busy_q  <= 1'b1;
      out_done_q  <= 1'b0;
      out_ticks_q <= start_rem;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign busy_res_o   = out_busy_q;
  assign done_res_o   = out_done_q;
  assign ticks_left_o = out_ticks_q;

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !q_stat_i.empty)
    else $error("pop from empty queue");

  a_divp_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVP) |-> (steps_q != '0))
    else $error("decimal step count underflow");

  a_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && emit_start) |=>
      (out_valid_q && out_busy_q && !out_done_q && out_ticks_q != '0))
    else $error("start result malformed");

  a_no_emit_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !(emit_tick || emit_start))
    else $error("result overwritten while stalled");
`endif

endmodule

>>> rtl/microsecond_delay_timer_unit.sv
// Channel | Handshake                    | Payload
// --------+------------------------------+-------------------------------------
// in      | in_valid_i / in_stall_o      | action_i, microseconds_i
// out     | out_valid_o / out_stall_i    | busy_res_o, done_res_o, ticks_left_o
// cfg     | cfg_valid_i / cfg_ready_o    | cfg_data_i (prescale)
//
// Ticks leave the idle state one per clock while out_stall_i is low. A start request
// runs MUL, CHK, UWB/MUL/CHK per microsecond divide by ten (u), DIVP/PWB per product
// divide by ten (p) and FIN, with u + p <= 6, all through one shared multiplier.
// Reset clears the queue, the countdown state and the prescale register.
// The input queue lets requests in while the back end converts or the
// output register waits on out_stall_i.
module microsecond_delay_timer_unit #(
  parameter int CLOCK_HZ    = mdt_pkg::CLOCK_HZ_DEF,
  parameter int QUEUE_DEPTH = mdt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [mdt_pkg::WORD_W-1:0]     microseconds_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           busy_res_o,
  output logic                           done_res_o,
  output logic [mdt_pkg::WORD_W-1:0]     ticks_left_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mdt_pkg::PRESCALE_W-1:0] cfg_data_i
);
  import mdt_pkg::*;

  item_t   push_item, head_item;
  q_stat_t q_stat;
  logic    push, pop;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  mdt_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .microseconds_i (microseconds_i),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .item_o         (push_item)
  );

  mdt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .head_o (head_item),
    .stat_o (q_stat)
  );

  mdt_back #(
    .CLOCK_HZ (CLOCK_HZ)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .head_i       (head_item),
    .q_stat_i     (q_stat),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .ticks_left_o (ticks_left_o)
  );

endmodule
